FILE: rtl/register_vm_instruction_executor_assert.svh
// Assertion macros shared by the register machine executor RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define RVM_EXEC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RVM_EXEC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RVM_EXEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rvm_exec_pkg.sv
// Types and constants of the register machine executor.
// Depends on nothing; the RTL modules of the block refer to it by scoped names.
package rvm_exec_pkg;

	localparam logic [7:0] OP_MOV     = 8'd30;
	localparam logic [7:0] OP_MOVR    = 8'd31;
	localparam logic [7:0] OP_PUSH    = 8'd32;
	localparam logic [7:0] OP_POP     = 8'd33;
	localparam logic [7:0] OP_CMD     = 8'd34;
	localparam logic [7:0] OP_ADD     = 8'd35;
	localparam logic [7:0] OP_ADDR    = 8'd36;
	localparam logic [7:0] OP_SUB     = 8'd37;
	localparam logic [7:0] OP_SUBR    = 8'd38;
	localparam logic [7:0] OP_JUMP    = 8'd39;
	localparam logic [7:0] OP_JNZ     = 8'd40;
	localparam logic [7:0] OP_LESS    = 8'd41;
	localparam logic [7:0] OP_GREATER = 8'd42;
	localparam logic [7:0] OP_EQUAL   = 8'd43;
	localparam logic [7:0] OP_STORE   = 8'd44;
	localparam logic [7:0] OP_LOAD    = 8'd45;

	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_REG   = 3'd1;
	localparam logic [2:0] ERR_OVER  = 3'd2;
	localparam logic [2:0] ERR_UNDER = 3'd3;
	localparam logic [2:0] ERR_ADDR  = 3'd4;

	localparam int unsigned WORD_W = 32;

	// Where the register write data of an instruction comes from.
	typedef enum logic [1:0] {
		WB_ALU   = 2'd0,
		WB_STACK = 2'd1,
		WB_MEM   = 2'd2
	} wb_src_t;

	typedef struct packed {
		logic [7:0]               action;
		logic signed [WORD_W-1:0] first_operand;
		logic signed [WORD_W-1:0] second_operand;
	} instr_t;

	typedef struct packed {
		logic                     jump_taken;
		logic signed [WORD_W-1:0] jump_target;
		logic                     command_valid;
		logic signed [WORD_W-1:0] command_code;
		logic                     condition_flag;
		logic [2:0]               error_code;
	} result_t;

endpackage

FILE: rtl/rvm_exec_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Used for the value stack and the data memory; depends on rvm_exec_pkg for the word width.
module rvm_exec_ram #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [rvm_exec_pkg::WORD_W-1:0]  wr_data,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic [rvm_exec_pkg::WORD_W-1:0]  rd_data
);

	logic [rvm_exec_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/rvm_exec_regfile.sv
// Register file RAM with two read ports and one write port, reads registered.
// Per-entry valid bits make never-written registers read as zero; uses rvm_exec_pkg.
module rvm_exec_regfile #(
	parameter int unsigned REG_COUNT = 16,
	localparam int unsigned RIW = $clog2(REG_COUNT)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [RIW-1:0]                   rd_addr_a,
	input  logic [RIW-1:0]                   rd_addr_b,
	output logic [rvm_exec_pkg::WORD_W-1:0]  rd_data_a,
	output logic [rvm_exec_pkg::WORD_W-1:0]  rd_data_b,
	input  logic                             wr_en,
	input  logic [RIW-1:0]                   wr_addr,
	input  logic [rvm_exec_pkg::WORD_W-1:0]  wr_data
);

	logic [rvm_exec_pkg::WORD_W-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0]            valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= valid_q[rd_addr_a] ? mem[rd_addr_a] : '0;
			rd_data_b <= valid_q[rd_addr_b] ? mem[rd_addr_b] : '0;
		end
	end

endmodule

FILE: rtl/register_vm_instruction_executor.sv
// Channel  | Direction | Handshake                  | Payload
// instr    | in        | instr_valid / instr_stall   | rvm_exec_pkg::instr_t
// result   | out       | result_valid / result_stall | rvm_exec_pkg::result_t
//
// One result per instruction; a new instruction is taken every cycle when the output drains.
// After the accepting edge, stage 1 holds the register file data, stage 2 the data memory or
// stack data, and the output register then loads the result and raises result_valid.
// Reset clears the register file valid bits, stack count, flag and pipeline valids; no sweep.
// A stalled result freezes the pipeline once stage 2 holds a request waiting behind it.
//
// Top level of the register machine executor: pipeline, forwarding and control.
// Depends on rvm_exec_pkg, rvm_exec_regfile, rvm_exec_ram and the assertion macro header.
`include "register_vm_instruction_executor_assert.svh"

module register_vm_instruction_executor #(
	parameter int unsigned REG_COUNT   = 16,
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned MEM_WORDS   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  instr_valid,
	output logic                  instr_stall,
	input  rvm_exec_pkg::instr_t  instr,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rvm_exec_pkg::result_t result
);

	localparam int unsigned RIW = $clog2(REG_COUNT);
	localparam int unsigned SW  = $clog2(STACK_DEPTH);
	localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned MW  = $clog2(MEM_WORDS);
	localparam int unsigned W   = rvm_exec_pkg::WORD_W;

	logic advance;

	// Stage 1: operands and register read data.
	logic                 s1_valid_q;
	rvm_exec_pkg::instr_t instr_s1;

	// Stage 2: executed request waiting for memory or stack data and write-back.
	logic                  s2_valid_q;
	rvm_exec_pkg::result_t res_s2;
	logic [7:0]            op_s2;
	logic                  wen_s2;
	logic [RIW-1:0]        widx_s2;
	logic [W-1:0]          wdata_s2;
	rvm_exec_pkg::wb_src_t src_s2;

	// Write performed at the last advancing edge, missed by the register read of stage 1.
	logic           wbv_q;
	logic [RIW-1:0] wbidx_q;
	logic [W-1:0]   wbdata_q;

	logic                  result_valid_q;
	rvm_exec_pkg::result_t result_q;

	logic          flag_q;
	logic [CW-1:0] stack_cnt_q;
	logic [CW-1:0] stack_cnt_dec;

	logic [W-1:0] rf_rd_a;
	logic [W-1:0] rf_rd_b;
	logic [W-1:0] stack_rd;
	logic [W-1:0] mem_rd;
	logic [W-1:0] s2_wdata;
	logic         s2_write;

	logic [W-1:0]   ua;
	logic [W-1:0]   ub;
	logic [RIW-1:0] ia;
	logic [RIW-1:0] ib;
	logic           a_ok;
	logic           b_ok;
	logic [W-1:0]   ra;
	logic [W-1:0]   rb;

	rvm_exec_pkg::result_t res_s1;
	logic                  wen_s1;
	logic [W-1:0]          wdata_s1;
	rvm_exec_pkg::wb_src_t src_s1;
	logic                  push_en;
	logic                  pop_en;
	logic                  st_en;

	// Everything moves unless stage 2 holds a result and the output register cannot take it.
	assign advance     = !(s2_valid_q && result_valid_q && result_stall);
	assign instr_stall = !advance;

	rvm_exec_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (advance),
		.rd_addr_a(instr.first_operand[RIW-1:0]),
		.rd_addr_b(instr.second_operand[RIW-1:0]),
		.rd_data_a(rf_rd_a),
		.rd_data_b(rf_rd_b),
		.wr_en    (advance && s2_write),
		.wr_addr  (widx_s2),
		.wr_data  (s2_wdata)
	);

	assign stack_cnt_dec = stack_cnt_q - 1'b1;

	rvm_exec_ram #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (advance && s1_valid_q && push_en),
		.wr_addr(stack_cnt_q[SW-1:0]),
		.wr_data(ua),
		.rd_en  (advance),
		.rd_addr(stack_cnt_dec[SW-1:0]),
		.rd_data(stack_rd)
	);

	rvm_exec_ram #(
		.DEPTH(MEM_WORDS)
	) u_dmem (
		.clk    (clk),
		.wr_en  (advance && s1_valid_q && st_en),
		.wr_addr(ra[MW-1:0]),
		.wr_data(rb),
		.rd_en  (advance),
		.rd_addr(rb[MW-1:0]),
		.rd_data(mem_rd)
	);

	// Write data of the stage 2 request, also forwarded to stage 1.
	always_comb begin
		case (src_s2)
			rvm_exec_pkg::WB_STACK: s2_wdata = stack_rd;
			rvm_exec_pkg::WB_MEM:   s2_wdata = mem_rd;
			default:                s2_wdata = wdata_s2;
		endcase
	end

	assign s2_write = s2_valid_q && wen_s2;

	assign ua   = $unsigned(instr_s1.first_operand);
	assign ub   = $unsigned(instr_s1.second_operand);
	assign ia   = ua[RIW-1:0];
	assign ib   = ub[RIW-1:0];
	assign a_ok = ua < W'(REG_COUNT);
	assign b_ok = ub < W'(REG_COUNT);

	// Newest value first: the request in stage 2, then the write at the last edge.
	always_comb begin
		if (s2_write && widx_s2 == ia) begin
			ra = s2_wdata;
		end else if (wbv_q && wbidx_q == ia) begin
			ra = wbdata_q;
		end else begin
			ra = rf_rd_a;
		end
		if (s2_write && widx_s2 == ib) begin
			rb = s2_wdata;
		end else if (wbv_q && wbidx_q == ib) begin
			rb = wbdata_q;
		end else begin
			rb = rf_rd_b;
		end
	end

	always_comb begin
		res_s1                = '0;
		res_s1.condition_flag = flag_q;
		res_s1.error_code     = rvm_exec_pkg::ERR_OK;
		wen_s1                = 1'b0;
		wdata_s1              = ub;
		src_s1                = rvm_exec_pkg::WB_ALU;
		push_en               = 1'b0;
		pop_en                = 1'b0;
		st_en                 = 1'b0;
		case (instr_s1.action)
			rvm_exec_pkg::OP_MOV: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					wen_s1 = 1'b1;
				end
			end
			rvm_exec_pkg::OP_MOVR: begin
				if (!a_ok || !b_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					wen_s1   = 1'b1;
					wdata_s1 = rb;
				end
			end
			rvm_exec_pkg::OP_PUSH: begin
				if (stack_cnt_q >= CW'(STACK_DEPTH)) begin
					res_s1.error_code = rvm_exec_pkg::ERR_OVER;
				end else begin
					push_en = 1'b1;
				end
			end
			rvm_exec_pkg::OP_POP: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else if (stack_cnt_q == '0) begin
					res_s1.error_code = rvm_exec_pkg::ERR_UNDER;
				end else begin
					pop_en = 1'b1;
					wen_s1 = 1'b1;
					src_s1 = rvm_exec_pkg::WB_STACK;
				end
			end
			rvm_exec_pkg::OP_CMD: begin
				res_s1.command_valid = 1'b1;
				res_s1.command_code  = instr_s1.first_operand;
			end
			rvm_exec_pkg::OP_ADD, rvm_exec_pkg::OP_SUB: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					wen_s1   = 1'b1;
					wdata_s1 = (instr_s1.action == rvm_exec_pkg::OP_ADD) ? ra + ub : ra - ub;
				end
			end
			rvm_exec_pkg::OP_ADDR, rvm_exec_pkg::OP_SUBR: begin
				if (!a_ok || !b_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					wen_s1   = 1'b1;
					wdata_s1 = (instr_s1.action == rvm_exec_pkg::OP_ADDR) ? ra + rb : ra - rb;
				end
			end
			rvm_exec_pkg::OP_JUMP: begin
				res_s1.jump_taken  = 1'b1;
				res_s1.jump_target = instr_s1.first_operand;
			end
			rvm_exec_pkg::OP_JNZ: begin
				if (flag_q) begin
					res_s1.jump_taken  = 1'b1;
					res_s1.jump_target = instr_s1.first_operand;
				end
			end
			rvm_exec_pkg::OP_LESS: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					res_s1.condition_flag = $signed(ra) < $signed(ub);
				end
			end
			rvm_exec_pkg::OP_GREATER: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					res_s1.condition_flag = $signed(ub) < $signed(ra);
				end
			end
			rvm_exec_pkg::OP_EQUAL: begin
				if (!a_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else begin
					res_s1.condition_flag = (ra == ub);
				end
			end
			rvm_exec_pkg::OP_STORE: begin
				if (!a_ok || !b_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else if (ra >= W'(MEM_WORDS)) begin
					res_s1.error_code = rvm_exec_pkg::ERR_ADDR;
				end else begin
					st_en = 1'b1;
				end
			end
			rvm_exec_pkg::OP_LOAD: begin
				if (!a_ok || !b_ok) begin
					res_s1.error_code = rvm_exec_pkg::ERR_REG;
				end else if (rb >= W'(MEM_WORDS)) begin
					res_s1.error_code = rvm_exec_pkg::ERR_ADDR;
				end else begin
					wen_s1 = 1'b1;
					src_s1 = rvm_exec_pkg::WB_MEM;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			s2_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
			wbv_q          <= 1'b0;
			flag_q         <= 1'b0;
			stack_cnt_q    <= '0;
		end else if (advance) begin
			s1_valid_q <= instr_valid;
			s2_valid_q <= s1_valid_q;
			wbv_q      <= s2_write;
			if (s1_valid_q) begin
				flag_q <= res_s1.condition_flag;
				if (push_en) begin
					stack_cnt_q <= stack_cnt_q + 1'b1;
				end else if (pop_en) begin
					stack_cnt_q <= stack_cnt_dec;
				end
			end
			if (s2_valid_q) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			instr_s1 <= instr;
			res_s2   <= res_s1;
			op_s2    <= instr_s1.action;
			wen_s2   <= s1_valid_q && wen_s1;
			widx_s2  <= ia;
			wdata_s2 <= wdata_s1;
			src_s2   <= src_s1;
			wbidx_q  <= widx_s2;
			wbdata_q <= s2_wdata;
			if (s2_valid_q) begin
				result_q <= res_s2;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RVM_EXEC_ASSERT_ALWAYS(a_stack_bound, stack_cnt_q <= CW'(STACK_DEPTH),
		"stack count above depth")
	`RVM_EXEC_ASSERT_IMP(a_err_quiet,
		result_valid && result.error_code != rvm_exec_pkg::ERR_OK,
		!result.jump_taken && !result.command_valid, "error result carries a jump or command")
	`RVM_EXEC_ASSERT_NEXT(a_pop_count, advance && s1_valid_q && pop_en,
		stack_cnt_q == CW'($past(stack_cnt_q) - 1'b1), "pop did not decrement the stack count")
	`RVM_EXEC_ASSERT_IMP(a_jump_op, s2_valid_q && res_s2.jump_taken,
		op_s2 == rvm_exec_pkg::OP_JUMP || op_s2 == rvm_exec_pkg::OP_JNZ,
		"jump taken by a non-jump instruction")

endmodule
